/* rtl/srpp_pkg.sv */
// Shared types and constants for the sensor record packet packer.
`timescale 1ns / 1ps
`default_nettype none

package srpp_pkg;

  // Payload body limit: a record fits only while fill + size stays below it
  localparam int MaxBodyBytes = 32;
  // Most bytes one item emits: scale marker, long time record, long value
  localparam int MaxBytes     = 11;
  localparam int CntW         = $clog2(MaxBytes + 1);
  localparam int PtrW         = $clog2(MaxBytes);

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_ADD   = 1'b1
  } op_e;

  // Value kinds
  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindShort = 2'd1;
  localparam logic [1:0] KindLong  = 2'd2;

  // Length codes in the low two bits of a record tag byte
  localparam logic [1:0] LenOne  = 2'd0;
  localparam logic [1:0] LenTwo  = 2'd1;
  localparam logic [1:0] LenFour = 2'd2;

  localparam logic [5:0] TimeTag   = 6'd1;
  localparam logic [7:0] ScaleMark = 8'hf0;

  typedef struct packed {
    op_e         op;
    logic [31:0] timestamp;
    logic [5:0]  tag;
    logic [31:0] reading;
    logic [1:0]  value_kind;
    logic [3:0]  exponent;
  } item_t;

  typedef struct packed {
    logic [6:0]  fill;
    logic [31:0] last_time;
    logic [3:0]  scale;
    logic        full;
  } state_t;

  // Everything one item produces, ready to be shifted out byte by byte
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic [6:0]               base;
    logic [6:0]               end_fill;
    logic [31:0]              header;
    logic                     hdr_valid;
    logic                     ok;
  } batch_t;

endpackage

`default_nettype wire

/* rtl/srpp_encode.sv */
// Record encoder: turns one item and the packer state into a byte batch.
`timescale 1ns / 1ps
`default_nettype none

module srpp_encode
  import srpp_pkg::*;
(
  input  item_t       item_i,
  input  state_t      state_i,
  input  logic [9:0]  session_i,
  output batch_t      batch_o,
  output state_t      state_o
);

  typedef struct packed {
    logic [4:0][7:0] b;
    logic [2:0]      len;
    logic [2:0]      need;
  } seg_t;

  localparam logic [7:0] MaxBody8 = 8'(MaxBodyBytes);

  // One tagged record; a short record always reserves three bytes
  function automatic seg_t build_rec(logic [5:0] name, logic [31:0] v, logic [1:0] kind);
    seg_t s;
    s = '0;
    case (kind)
      KindByte: begin
        s.b[0] = {name, LenOne};
        s.b[1] = v[7:0];
        s.len  = 3'd2;
        s.need = 3'd2;
      end
      KindShort: begin
        s.need = 3'd3;
        if (v[15:8] != 8'd0) begin
          s.b[0] = {name, LenTwo};
          s.b[1] = v[15:8];
          s.b[2] = v[7:0];
          s.len  = 3'd3;
        end else begin
          s.b[0] = {name, LenOne};
          s.b[1] = v[7:0];
          s.len  = 3'd2;
        end
      end
      default: begin
        s.b[0] = {name, LenFour};
        s.b[1] = v[31:24];
        s.b[2] = v[23:16];
        s.b[3] = v[15:8];
        s.b[4] = v[7:0];
        s.len  = 3'd5;
        s.need = 3'd5;
      end
    endcase
    return s;
  endfunction

  function automatic logic fits(logic [6:0] fill, logic full, logic [2:0] need);
    return !full && ((8'(fill) + 8'(need)) < MaxBody8);
  endfunction

  seg_t        tseg, vseg;
  logic [1:0]  tkind;
  logic        ls;
  logic [2:0]  lt, lv;
  logic [6:0]  fill;
  logic        full, ok;
  logic [3:0]  rel_t, rel_v;

  // Record selection and state update
  always_comb begin
    state_o = state_i;
    ls      = 1'b0;
    lt      = 3'd0;
    lv      = 3'd0;
    ok      = 1'b0;
    tkind   = KindLong;
    if (item_i.timestamp[31:16] == state_i.last_time[31:16]) begin
      tkind = (item_i.timestamp[15:8] == state_i.last_time[15:8]) ? KindByte : KindShort;
    end
    tseg = build_rec(TimeTag, item_i.timestamp, tkind);
    vseg = build_rec(item_i.tag, item_i.reading, item_i.value_kind);

    if (item_i.op == OP_BEGIN) begin
      tseg = build_rec(TimeTag, {24'd0, item_i.timestamp[7:0]}, KindByte);
      fill = 7'd0;
      full = 1'b0;
      state_o.scale     = 4'd0;
      state_o.last_time = item_i.timestamp;
      if (fits(fill, full, tseg.need)) begin
        lt   = tseg.len;
        fill = fill + 7'(tseg.len);
        ok   = 1'b1;
      end else begin
        full = 1'b1;
      end
    end else begin
      fill = state_i.fill;
      full = state_i.full;
      ok   = 1'b1;
      // scale marker
      if (item_i.exponent != state_i.scale) begin
        if (fits(fill, full, 3'd1)) begin
          ls            = 1'b1;
          fill          = fill + 7'd1;
          state_o.scale = item_i.exponent;
        end else begin
          full = 1'b1;
          ok   = 1'b0;
        end
      end
      // time record
      if (ok && (item_i.timestamp != state_i.last_time)) begin
        state_o.last_time = item_i.timestamp;
        if (fits(fill, full, tseg.need)) begin
          lt   = tseg.len;
          fill = fill + 7'(tseg.len);
        end else begin
          full = 1'b1;
          ok   = 1'b0;
        end
      end
      // value record
      if (ok) begin
        if (fits(fill, full, vseg.need)) begin
          lv   = vseg.len;
          fill = fill + 7'(vseg.len);
        end else begin
          full = 1'b1;
          ok   = 1'b0;
        end
      end
    end
    state_o.fill = fill;
    state_o.full = full;
  end

  // Batch assembly: each position picks from the segment it falls into
  always_comb begin
    batch_o           = '0;
    batch_o.cnt       = CntW'(ls) + CntW'(lt) + CntW'(lv);
    batch_o.base      = (item_i.op == OP_BEGIN) ? 7'd0 : state_i.fill;
    batch_o.end_fill  = state_o.fill;
    batch_o.hdr_valid = (item_i.op == OP_BEGIN);
    batch_o.header    = (item_i.op == OP_BEGIN) ? {session_i, item_i.timestamp[26:5]} : 32'd0;
    batch_o.ok        = ok;
    rel_t             = 4'd0;
    rel_v             = 4'd0;
    for (int k = 0; k < MaxBytes; k++) begin
      rel_t = 4'(k) - 4'(ls);
      rel_v = rel_t - 4'(lt);
      if (4'(k) < 4'(ls)) begin
        batch_o.bytes[k] = ScaleMark | {4'd0, item_i.exponent};
      end else if (rel_t < 4'(lt)) begin
        batch_o.bytes[k] = tseg.b[rel_t[2:0]];
      end else if (rel_v < 4'(lv)) begin
        batch_o.bytes[k] = vseg.b[rel_v[2:0]];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sensor_record_packet_packer.sv */
// Top level of the sensor record packet packer: input register, encoder, byte serializer.
`timescale 1ns / 1ps
`default_nettype none

// Each transaction on the input channel yields between one and eleven result
// transactions, one payload body byte per cycle while out_stall_i is low: a
// begin item gives two, an add item up to eleven (scale marker, time record,
// value record), and an item that emits nothing gives a single result with
// byte_valid low. The output byte serializer sets the rate: an item holds the
// output until all its results are taken. An item sits in the input register
// and is encoded in the cycle it moves into the serializer, so the next item is
// taken while the previous batch is still being shifted out, and batches follow
// each other without a gap. Users write the session number register over its
// own port only while the block is idle (not enforced); it is always ready.
module sensor_record_packet_packer
  import srpp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [9:0]        cfg_data_i,
  // input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [31:0]       timestamp_i,
  input  logic [5:0]        tag_i,
  input  logic [31:0]       reading_i,
  input  logic [1:0]        value_kind_i,
  input  logic signed [3:0] exponent_i,
  // result bytes
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic [5:0]        byte_index_o,
  output logic              byte_valid_o,
  output logic [31:0]       header_word_o,
  output logic              header_valid_o,
  output logic              accepted_o,
  output logic [6:0]        body_length_o,
  output logic              last_o
);

  logic            in_valid_q;
  item_t           in_q;
  state_t          state_q, state_d;
  logic [9:0]      session_q;
  batch_t          bat_q, bat_d;
  logic            bat_valid_q;
  logic [PtrW-1:0] ptr_q;
  logic            in_take, out_take, is_last, move;
  logic [5:0]      pos;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign out_take    = bat_valid_q && !out_stall_i;
  assign is_last     = (bat_q.cnt == '0) || (CntW'(ptr_q) == bat_q.cnt - CntW'(1));
  assign move        = in_valid_q && (!bat_valid_q || (out_take && is_last));
  assign in_stall_o  = in_valid_q && !move;
  assign in_take     = in_valid_i && !in_stall_o;

  // Session number register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q <= 10'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      session_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.op         <= op_e'(operation_i);
      in_q.timestamp  <= timestamp_i;
      in_q.tag        <= tag_i;
      in_q.reading    <= reading_i;
      in_q.value_kind <= value_kind_i;
      in_q.exponent   <= exponent_i;
    end
  end

  srpp_encode u_encode (
    .item_i    (in_q),
    .state_i   (state_q),
    .session_i (session_q),
    .batch_o   (bat_d),
    .state_o   (state_d)
  );

  // Packer state commits when the item moves into the serializer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (move) begin
      state_q <= state_d;
    end
  end

  // Byte serializer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bat_valid_q <= 1'b0;
      ptr_q       <= '0;
    end else if (move) begin
      bat_valid_q <= 1'b1;
      ptr_q       <= '0;
    end else if (out_take) begin
      if (is_last) begin
        bat_valid_q <= 1'b0;
        ptr_q       <= '0;
      end else begin
        ptr_q <= ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      bat_q <= bat_d;
    end
  end

  // Result fields
  assign pos            = bat_q.base[5:0] + 6'(ptr_q);
  assign out_valid_o    = bat_valid_q;
  assign byte_valid_o   = (bat_q.cnt != '0);
  assign out_byte_o     = byte_valid_o ? bat_q.bytes[ptr_q] : 8'd0;
  assign byte_index_o   = byte_valid_o ? pos : 6'd0;
  assign body_length_o  = byte_valid_o ? (7'(pos) + 7'd1) : bat_q.end_fill;
  assign header_word_o  = bat_q.header;
  assign header_valid_o = bat_q.hdr_valid;
  assign last_o         = is_last;
  assign accepted_o     = is_last && bat_q.ok;

endmodule

`default_nettype wire
